// File: rtl/bracket_loop_byte_machine_core_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bracket loop byte machine core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRACKET_LOOP_BYTE_MACHINE_CORE_UNIT_ASSERT_SVH
`define BRACKET_LOOP_BYTE_MACHINE_CORE_UNIT_ASSERT_SVH

// same-cycle implication
`define BLBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/blbm_pkg.sv
// ----------------------------------------------------------------------------
// blbm_pkg
// Shared constants, opcodes, phase codes and control structs for the
// bracket loop byte machine core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blbm_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int ADDR_BITS_DEF   = 11;
    localparam int BUS_ADDR_W      = 11;
    localparam int DATA_W          = 8;
    localparam int CMD_W           = 2;
    localparam int SKIP_W          = 11;
    localparam int STEP_W          = 2;

    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_HIGH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOW  = 2'd1;

    localparam logic [DATA_W-1:0] OP_RIGHT = 8'h3E;
    localparam logic [DATA_W-1:0] OP_LEFT  = 8'h3C;
    localparam logic [DATA_W-1:0] OP_INC   = 8'h2B;
    localparam logic [DATA_W-1:0] OP_DEC   = 8'h2D;
    localparam logic [DATA_W-1:0] OP_OUT   = 8'h2E;
    localparam logic [DATA_W-1:0] OP_OPEN  = 8'h5B;
    localparam logic [DATA_W-1:0] OP_CLOSE = 8'h5D;

    typedef enum logic [2:0] {
        PH_NEXT = 3'd0,
        PH_RDI  = 3'd1,
        PH_RDD  = 3'd2,
        PH_WR   = 3'd3,
        PH_IO   = 3'd4,
        PH_EXEC = 3'd5
    } phase_t;

    typedef struct packed {
        logic io;
        logic we;
        logic ram;
        logic rom;
    } strobe_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stack_stat_t;

    typedef struct packed {
        logic [BUS_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     data;
        strobe_t               stb;
    } bus_result_t;

endpackage

// File: rtl/blbm_if.sv
// ----------------------------------------------------------------------------
// blbm_item_if / blbm_result_if
// Valid/ready channels for clock phase items and bus pin results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blbm_item_if
    import blbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic              reset_pin;
    logic [DATA_W-1:0] bus_read_data;

    modport source (output valid, output command, output reset_pin, output bus_read_data,
                    input ready);
    modport sink   (input valid, input command, input reset_pin, input bus_read_data,
                    output ready);
endinterface

interface blbm_result_if
    import blbm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BUS_ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0]     bus_write_data;
    logic                  rom_enable;
    logic                  ram_enable;
    logic                  write_enable;
    logic                  io_enable;

    modport source (output valid, output bus_address, output bus_write_data,
                    output rom_enable, output ram_enable, output write_enable,
                    output io_enable, input ready);
    modport sink   (input valid, input bus_address, input bus_write_data,
                    input rom_enable, input ram_enable, input write_enable,
                    input io_enable, output ready);
endinterface

// File: rtl/blbm_stack.sv
// ----------------------------------------------------------------------------
// blbm_stack
// Bracket return stack: memory, fill count and a registered top entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blbm_stack
    import blbm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stack_ctrl_t          ctrl,
    input  logic [ADDR_BITS-1:0] push_data,
    output logic [ADDR_BITS-1:0] top,
    output stack_stat_t          stat
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [ADDR_BITS-1:0] mem [STACK_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     pop_idx;
    logic [ADDR_BITS-1:0] top_reg;

    assign pop_idx = count_reg - CNT_W'(2);

    always_comb
    begin
        count_next = count_reg;
        priority if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[count_reg[IDX_W-1:0]] <= push_data;
        end
    end

    // track the entry below the top on a pop, bypass on a push
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            top_reg <= push_data;
        end
        else if (ctrl.pop)
        begin
            top_reg <= mem[pop_idx[IDX_W-1:0]];
        end
    end

    assign top        = top_reg;
    assign stat.full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: rtl/blbm_exec.sv
// ----------------------------------------------------------------------------
// blbm_exec
// Machine state registers and the single-pass next-state logic for one
// clock phase: fetch, bus cycle start, read latch and instruction steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blbm_exec
    import blbm_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [CMD_W-1:0]     command,
    input  logic                 reset_pin,
    input  logic [DATA_W-1:0]    rd_byte,
    input  logic [ADDR_BITS-1:0] stack_top,
    input  stack_stat_t          stat,
    output stack_ctrl_t          ctrl,
    output logic [ADDR_BITS-1:0] push_data,
    output bus_result_t          result
);

    logic [ADDR_BITS-1:0] pc_reg, pc_next, pc_cur, pc_inc;
    logic [ADDR_BITS-1:0] cp_reg, cp_next, cp_cur;
    logic [DATA_W-1:0]    cv_reg, cv_next, cv_cur;
    logic [DATA_W-1:0]    op_reg, op_next;
    phase_t               phase_reg, phase_next, phase_cur;
    logic [STEP_W-1:0]    step_reg, step_next, step_cur;
    logic [SKIP_W-1:0]    skip_reg, skip_next, skip_cur;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    strobe_t              stb_reg, stb_next, stb_cur;
    logic                 full_cur, empty_cur;
    logic                 push, pop, soft_rst, bump;
    logic [ADDR_BITS+BUS_ADDR_W-1:0] addr_wide;

    // apply the reset pin ahead of the phase
    always_comb
    begin
        pc_cur    = pc_reg;
        cp_cur    = cp_reg;
        cv_cur    = cv_reg;
        phase_cur = phase_reg;
        step_cur  = step_reg;
        skip_cur  = skip_reg;
        stb_cur   = stb_reg;
        full_cur  = stat.full;
        empty_cur = stat.empty;
        if (reset_pin)
        begin
            pc_cur    = '0;
            cp_cur    = '0;
            cv_cur    = '0;
            phase_cur = PH_NEXT;
            step_cur  = '0;
            skip_cur  = '0;
            stb_cur   = '0;
            full_cur  = 1'b0;
            empty_cur = 1'b1;
        end
    end

    assign pc_inc = pc_cur + ADDR_BITS'(1);

    always_comb
    begin
        pc_next    = pc_cur;
        cp_next    = cp_cur;
        cv_next    = cv_cur;
        op_next    = op_reg;
        phase_next = phase_cur;
        step_next  = step_cur;
        skip_next  = skip_cur;
        addr_next  = addr_reg;
        data_next  = data_reg;
        stb_next   = stb_cur;
        push       = 1'b0;
        pop        = 1'b0;
        soft_rst   = 1'b0;
        bump       = 1'b0;

        unique case (command)
            CMD_HIGH:
            begin
                stb_next = '0;
                unique case (phase_cur)
                    PH_NEXT:
                    begin
                        step_next    = '0;
                        stb_next.rom = 1'b1;
                        addr_next    = pc_cur;
                        phase_next   = PH_RDI;
                    end
                    PH_EXEC:
                    begin
                        if (skip_cur != '0)
                        begin
                            if (op_reg == OP_OPEN)
                            begin
                                if (skip_cur != SKIP_MAX)
                                begin
                                    skip_next = skip_cur + SKIP_W'(1);
                                end
                            end
                            else if (op_reg == OP_CLOSE)
                            begin
                                skip_next = skip_cur - SKIP_W'(1);
                            end
                            pc_next    = pc_inc;
                            phase_next = PH_NEXT;
                        end
                        else
                        begin
                            bump = 1'b1;
                            unique case (op_reg)
                                OP_RIGHT:
                                begin
                                    cp_next    = cp_cur + ADDR_BITS'(1);
                                    pc_next    = pc_inc;
                                    phase_next = PH_NEXT;
                                end
                                OP_LEFT:
                                begin
                                    cp_next    = cp_cur - ADDR_BITS'(1);
                                    pc_next    = pc_inc;
                                    phase_next = PH_NEXT;
                                end
                                OP_INC, OP_DEC:
                                begin
                                    unique case (step_cur)
                                        2'd0:
                                        begin
                                            stb_next.ram = 1'b1;
                                            addr_next    = cp_cur;
                                            phase_next   = PH_RDD;
                                        end
                                        2'd1:
                                        begin
                                            cv_next = (op_reg == OP_INC) ?
                                                cv_cur + DATA_W'(1) : cv_cur - DATA_W'(1);
                                        end
                                        2'd2:
                                        begin
                                            stb_next.ram = 1'b1;
                                            stb_next.we  = 1'b1;
                                            addr_next    = cp_cur;
                                            data_next    = cv_cur;
                                            phase_next   = PH_WR;
                                        end
                                        default:
                                        begin
                                            pc_next    = pc_inc;
                                            phase_next = PH_NEXT;
                                        end
                                    endcase
                                end
                                OP_OUT:
                                begin
                                    unique case (step_cur)
                                        2'd0:
                                        begin
                                            stb_next.ram = 1'b1;
                                            addr_next    = cp_cur;
                                            phase_next   = PH_RDD;
                                        end
                                        2'd1:
                                        begin
                                            stb_next.io = 1'b1;
                                            data_next   = cv_cur;
                                            phase_next  = PH_IO;
                                        end
                                        2'd2:
                                        begin
                                            pc_next    = pc_inc;
                                            phase_next = PH_NEXT;
                                        end
                                        default:
                                        begin
                                            soft_rst = 1'b1;
                                        end
                                    endcase
                                end
                                OP_OPEN:
                                begin
                                    unique case (step_cur)
                                        2'd0:
                                        begin
                                            stb_next.ram = 1'b1;
                                            addr_next    = cp_cur;
                                            phase_next   = PH_RDD;
                                        end
                                        2'd1:
                                        begin
                                            if (cv_cur == '0)
                                            begin
                                                skip_next = SKIP_W'(1);
                                            end
                                            else if (!full_cur)
                                            begin
                                                push = 1'b1;
                                            end
                                            pc_next    = pc_inc;
                                            phase_next = PH_NEXT;
                                        end
                                        default:
                                        begin
                                            soft_rst = 1'b1;
                                        end
                                    endcase
                                end
                                OP_CLOSE:
                                begin
                                    unique case (step_cur)
                                        2'd0:
                                        begin
                                            stb_next.ram = 1'b1;
                                            addr_next    = cp_cur;
                                            phase_next   = PH_RDD;
                                        end
                                        2'd1:
                                        begin
                                            if (cv_cur != '0)
                                            begin
                                                if (!empty_cur)
                                                begin
                                                    pc_next = stack_top;
                                                end
                                                phase_next = PH_NEXT;
                                            end
                                            else
                                            begin
                                                pop        = !empty_cur;
                                                pc_next    = pc_inc;
                                                phase_next = PH_NEXT;
                                            end
                                        end
                                        default:
                                        begin
                                            soft_rst = 1'b1;
                                        end
                                    endcase
                                end
                                default:
                                begin
                                    bump       = 1'b0;
                                    pc_next    = pc_inc;
                                    phase_next = PH_NEXT;
                                end
                            endcase
                            if (bump)
                            begin
                                step_next = step_cur + STEP_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        soft_rst = 1'b1;
                    end
                endcase
            end
            CMD_LOW:
            begin
                unique case (phase_cur)
                    PH_RDI:
                    begin
                        op_next    = rd_byte;
                        phase_next = PH_EXEC;
                    end
                    PH_RDD:
                    begin
                        cv_next    = rd_byte;
                        phase_next = PH_EXEC;
                    end
                    PH_WR, PH_IO:
                    begin
                        phase_next = PH_EXEC;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (soft_rst)
        begin
            pc_next    = '0;
            cp_next    = '0;
            cv_next    = '0;
            phase_next = PH_NEXT;
            step_next  = '0;
            skip_next  = '0;
            stb_next   = '0;
            push       = 1'b0;
            pop        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            cp_reg    <= '0;
            cv_reg    <= '0;
            op_reg    <= '0;
            phase_reg <= PH_NEXT;
            step_reg  <= '0;
            skip_reg  <= '0;
            addr_reg  <= '0;
            data_reg  <= '0;
            stb_reg   <= '0;
        end
        else if (accept)
        begin
            pc_reg    <= pc_next;
            cp_reg    <= cp_next;
            cv_reg    <= cv_next;
            op_reg    <= op_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            skip_reg  <= skip_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            stb_reg   <= stb_next;
        end
    end

    assign ctrl.clear = accept && (reset_pin || soft_rst);
    assign ctrl.push  = accept && push;
    assign ctrl.pop   = accept && pop;
    assign push_data  = pc_inc;

    assign addr_wide   = {{BUS_ADDR_W{1'b0}}, addr_next};
    assign result.addr = addr_wide[BUS_ADDR_W-1:0];
    assign result.data = data_next;
    assign result.stb  = stb_next;

endmodule

// File: rtl/bracket_loop_byte_machine_core_unit.sv
// ----------------------------------------------------------------------------
// bracket_loop_byte_machine_core_unit
// Tape-language byte processor core: one clock phase in, one set of bus
// pin values out.
//
//   channel  | dir | transaction
//   ---------+-----+---------------------------------------------------
//   item     | in  | command, reset_pin, bus_read_data (one clock phase)
//   result   | out | bus_address, bus_write_data, rom/ram/write/io enable
//
// One item per cycle while the result is not stalled; its result is registered
// and shows in the cycle after the item is taken. The loop through the
// machine state registers and the return stack count sets that rate.
// rst_n clears all machine state; the stack memory holds no reset.
// A stalled result holds; a new item is taken in the cycle it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_loop_byte_machine_core_unit
    import blbm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input logic            clk,
    input logic            rst_n,
    blbm_item_if.sink      item,
    blbm_result_if.source  result
);

    logic                 item_ready;
    logic                 accept;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    bus_result_t          res_reg;
    bus_result_t          res_next;
    stack_ctrl_t          stk_ctrl;
    stack_stat_t          stk_stat;
    logic [ADDR_BITS-1:0] stk_top;
    logic [ADDR_BITS-1:0] stk_push_data;

    assign item_ready = !res_valid_reg || result.ready;
    assign item.ready = item_ready;
    assign accept     = item.valid && item_ready;

    blbm_exec #(
        .ADDR_BITS (ADDR_BITS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (item.command),
        .reset_pin (item.reset_pin),
        .rd_byte   (item.bus_read_data),
        .stack_top (stk_top),
        .stat      (stk_stat),
        .ctrl      (stk_ctrl),
        .push_data (stk_push_data),
        .result    (res_next)
    );

    blbm_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (stk_ctrl),
        .push_data (stk_push_data),
        .top       (stk_top),
        .stat      (stk_stat)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        priority if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.bus_address    = res_reg.addr;
    assign result.bus_write_data = res_reg.data;
    assign result.rom_enable     = res_reg.stb.rom;
    assign result.ram_enable     = res_reg.stb.ram;
    assign result.write_enable   = res_reg.stb.we;
    assign result.io_enable      = res_reg.stb.io;

endmodule

// File: rtl/blbm_checker.sv
// ----------------------------------------------------------------------------
// blbm_checker
// Port-level checks on the core's handshake and bus strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bracket_loop_byte_machine_core_unit_assert.svh"

module blbm_checker
    import blbm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic [CMD_W-1:0]      command,
    input logic                  reset_pin,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [BUS_ADDR_W-1:0] bus_address,
    input logic                  rom_enable,
    input logic                  ram_enable,
    input logic                  write_enable,
    input logic                  io_enable
);

    `BLBM_ASSERT_NEXT(a_hold_valid, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `BLBM_ASSERT_NEXT(a_one_cycle, item_valid && item_ready, result_valid, "no result after transaction")
    `BLBM_ASSERT_NOW(a_strobes, result_valid, $onehot0({rom_enable, ram_enable, io_enable}) && (!write_enable || ram_enable), "conflicting bus strobes")
    `BLBM_ASSERT_NEXT(a_reset_fetch, item_valid && item_ready && reset_pin && (command == CMD_HIGH), rom_enable && !ram_enable && !io_enable && (bus_address == '0), "reset fetch not at zero")

endmodule

bind bracket_loop_byte_machine_core_unit blbm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .command      (item.command),
    .reset_pin    (item.reset_pin),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .bus_address  (result.bus_address),
    .rom_enable   (result.rom_enable),
    .ram_enable   (result.ram_enable),
    .write_enable (result.write_enable),
    .io_enable    (result.io_enable)
);
